// File: design/camera_primary_ray_direction_unit_macros.svh
// Assertion macros for the camera primary ray direction unit.
// No dependencies; taken in by files that carry concurrent checks.
`ifndef CAMERA_PRIMARY_RAY_DIRECTION_UNIT_MACROS_SVH
`define CAMERA_PRIMARY_RAY_DIRECTION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CRD_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("check failed");
`define CRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CRD_ASSERT(lbl, clk, rstn, expr)
`define CRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/crd_pkg.sv
// Shared constants and helpers for the camera primary ray direction unit.
// No dependencies.
`timescale 1ns / 1ps
package crd_pkg;
    localparam int COMPONENT_WIDTH_DEF = 21;
    localparam int DIR_FRAC_BITS_DEF   = 14;
    localparam int COORD_W   = 17;
    localparam int OUT_W     = 16;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 2;
    localparam int NORM_BITS = 30;
    localparam int SQ_W      = 2 * NORM_BITS + 2;
    localparam int ROOT_W    = NORM_BITS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        t_cfg_corner = 2'd0,
        t_cfg_horiz  = 2'd1,
        t_cfg_vert   = 2'd2,
        t_cfg_none   = 2'd3
    } t_cfg_idx;

    // position of the highest set bit plus one, zero for zero
    function automatic logic [6:0] bit_len64(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) n = 7'(i + 1);
        end
        return n;
    endfunction
endpackage

// File: design/crd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on crd_pkg.
`timescale 1ns / 1ps
module crd_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [crd_pkg::SQ_W-1:0]   i_sq,
    output logic [crd_pkg::ROOT_W-1:0] o_root
);
    localparam int SW = crd_pkg::SQ_W;
    localparam int QW = crd_pkg::ROOT_W;
    localparam int RW = QW + 3;

    logic [SW-1:0] r_s    [QW];
    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_root [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [SW-1:0] p_s;
        logic [RW-1:0] p_rem, rem_sh, trial, n_rem;
        logic [QW-1:0] p_root, n_root;
        logic          ge;
        if (i == 0) begin : g_first
            assign p_s    = i_sq;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_s    = r_s[i-1];
            assign p_rem  = r_rem[i-1];
            assign p_root = r_root[i-1];
        end
        assign rem_sh = {p_rem[RW-3:0], p_s[SW-1 -: 2]};
        assign trial  = RW'({p_root, 2'b01});
        assign ge     = rem_sh >= trial;
        assign n_rem  = ge ? rem_sh - trial : rem_sh;
        assign n_root = {p_root[QW-2:0], ge};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[i]    <= p_s << 2;
                r_rem[i]  <= n_rem;
                r_root[i] <= n_root;
            end
        end
    end

    assign o_root = r_root[QW-1];
endmodule

// File: design/crd_div.sv
// Pipelined rounded divider lane: (a * 2^FB + den/2) / den, one bit a stage.
// Depends on crd_pkg.
`timescale 1ns / 1ps
module crd_div #(
    parameter int DIR_FRAC_BITS = crd_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [crd_pkg::NORM_BITS-1:0] i_num,
    input  logic [crd_pkg::ROOT_W-1:0]    i_den,
    output logic [DIR_FRAC_BITS:0]        o_quot
);
    localparam int QB  = DIR_FRAC_BITS + 1;
    localparam int NW  = crd_pkg::NORM_BITS + QB;
    localparam int DW  = crd_pkg::ROOT_W;
    localparam int DRW = DW + 1;

    logic [DRW-1:0] r_rem [QB+1];
    logic [QB-1:0]  r_low [QB+1];
    logic [QB-1:0]  r_q   [QB+1];
    logic [DW-1:0]  r_den [QB+1];

    logic [NW-1:0] num0;
    assign num0 = NW'({i_num, {DIR_FRAC_BITS{1'b0}}}) + NW'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DRW'(num0 >> QB);
            r_low[0] <= num0[QB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DRW-1:0] rem_sh;
        logic           ge;
        assign rem_sh = {r_rem[k-1][DRW-2:0], r_low[k-1][QB-1]};
        assign ge     = rem_sh >= DRW'(r_den[k-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? rem_sh - DRW'(r_den[k-1]) : rem_sh;
                r_low[k] <= r_low[k-1] << 1;
                r_q[k]   <= {r_q[k-1][QB-2:0], ge};
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quot = r_q[QB];
endmodule

// File: design/camera_primary_ray_direction_unit.sv
// Top level of the camera primary ray direction unit.
// Depends on crd_pkg, crd_sqrt, crd_div and the assertion macro header.
//
// Input stream: s_axis_tdata carries u_coord (bits 16:0) and v_coord (33:17),
// both unsigned Q1.16. Output stream: m_axis_tdata carries dir_x, dir_y,
// dir_z as signed 16-bit values with DIR_FRAC_BITS fraction bits; m_axis_tuser
// carries zero_length. Registers corner_offset, horizontal_span and
// vertical_span are written through i_cfg_we / i_cfg_index / i_cfg_data while
// the stream is idle.
// The datapath is one pipeline of 40 + DIR_FRAC_BITS stages (54 at the
// default): seven front stages (multiply, sum, max, bit length, scale,
// square, sum of squares), 31 square root stages of one root bit each, and
// DIR_FRAC_BITS + 2 divider stages, followed by the output register.
// One item is accepted every cycle while the pipeline is not frozen. Reset
// clears all valid bits and the configuration registers.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "camera_primary_ray_direction_unit_macros.svh"
module camera_primary_ray_direction_unit #(
    parameter int COMPONENT_WIDTH = crd_pkg::COMPONENT_WIDTH_DEF,
    parameter int DIR_FRAC_BITS   = crd_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,  // u_coord, v_coord
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,  // dir_x, dir_y, dir_z
    output logic [0:0]                    m_axis_tuser,  // zero_length
    input  logic                          i_cfg_we,
    input  logic [crd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crd_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int CW  = COMPONENT_WIDTH;
    localparam int UW  = crd_pkg::COORD_W;
    localparam int PW  = CW + UW + 1;
    localparam int DW  = CW + 19;
    localparam int MW  = DW - 1;
    localparam int BLW = $clog2(MW + 1);
    localparam int NB  = crd_pkg::NORM_BITS;
    localparam int QW  = crd_pkg::ROOT_W;
    localparam int QB  = DIR_FRAC_BITS + 1;
    localparam int NST = 40 + DIR_FRAC_BITS;
    localparam int SDK = 36 + DIR_FRAC_BITS;
    localparam int OW  = crd_pkg::OUT_W;
    localparam int QX  = (QB > OW) ? QB : OW;

    logic [crd_pkg::CFG_W-1:0] r_off, r_hor, r_ver;
    logic en;
    logic [NST-1:0] r_vld;
    logic r_out_valid;

    // front stages
    logic signed [PW-1:0] r1_pu [3];
    logic signed [PW-1:0] r1_pv [3];
    logic signed [CW-1:0] r1_off [3];
    logic [MW-1:0] r2_mag [3];
    logic [2:0]    r2_neg;
    logic [MW-1:0] r3_mag [3];
    logic [2:0]    r3_neg;
    logic [MW-1:0] r3_max;
    logic [MW-1:0] r4_mag [3];
    logic [BLW-1:0] r4_bl;
    logic [3:0]    r4_side;
    logic [NB-1:0] r5_a [3];
    logic [NB-1:0] r6_a [3];
    logic [2*NB-1:0] r6_sq [3];
    logic [NB-1:0] r7_a [3];
    logic [crd_pkg::SQ_W-1:0] r7_s;
    logic [NB-1:0] r_ad [QW][3];
    logic [3:0] r_sd [SDK];
    logic [QW-1:0] root;
    logic [DIR_FRAC_BITS:0] quot [3];
    logic [OW-1:0] r_dir [3];
    logic r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
            r_hor <= '0;
            r_ver <= '0;
        end else if (i_cfg_we) begin
            unique case (crd_pkg::t_cfg_idx'(i_cfg_index))
                crd_pkg::t_cfg_corner: r_off <= i_cfg_data;
                crd_pkg::t_cfg_horiz:  r_hor <= i_cfg_data;
                crd_pkg::t_cfg_vert:   r_ver <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NST-2:0], s_axis_tvalid};
            r_out_valid <= r_vld[NST-1];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [UW:0]  u_s, v_s;
        logic signed [DW-1:0] d;
        logic [DW-1:0] d_abs;
        logic [MW+NB-1:0] scaled;
        assign u_s = $signed({1'b0, s_axis_tdata[UW-1:0]});
        assign v_s = $signed({1'b0, s_axis_tdata[2*UW-1:UW]});
        assign d = DW'(r1_off[k]) * $signed(DW'(65536)) + DW'(r1_pu[k]) + DW'(r1_pv[k]);
        assign d_abs = d[DW-1] ? DW'(-d) : DW'(d);
        assign scaled = {r4_mag[k], {NB{1'b0}}} >> r4_bl;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_off[k] <= $signed(r_off[k*CW +: CW]);
                r1_pu[k]  <= PW'(u_s * $signed(r_hor[k*CW +: CW]));
                r1_pv[k]  <= PW'(v_s * $signed(r_ver[k*CW +: CW]));
                r2_mag[k] <= d_abs[MW-1:0];
                r2_neg[k] <= d[DW-1];
                r3_mag[k] <= r2_mag[k];
                r4_mag[k] <= r3_mag[k];
                r5_a[k]   <= scaled[NB-1:0];
                r6_a[k]   <= r5_a[k];
                r6_sq[k]  <= r5_a[k] * r5_a[k];
                r7_a[k]   <= r6_a[k];
            end
        end
        crd_div #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_ad[QW-1][k]),
            .i_den  (root),
            .o_quot (quot[k])
        );
    end

    logic [MW-1:0] max01;
    assign max01 = (r2_mag[0] > r2_mag[1]) ? r2_mag[0] : r2_mag[1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_neg  <= r2_neg;
            r3_max  <= (r2_mag[2] > max01) ? r2_mag[2] : max01;
            r4_bl   <= BLW'(crd_pkg::bit_len64(64'(r3_max)));
            r4_side <= {r3_max == '0, r3_neg};
            r7_s    <= crd_pkg::SQ_W'(r6_sq[0]) + crd_pkg::SQ_W'(r6_sq[1])
                     + crd_pkg::SQ_W'(r6_sq[2]);
            r_ad[0] <= r7_a;
            r_sd[0] <= r4_side;
            for (int i = 1; i < QW; i++) r_ad[i] <= r_ad[i-1];
            for (int i = 1; i < SDK; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    crd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r7_s),
        .o_root (root)
    );

    // sign, zero flag and masking to the 16-bit fields
    for (genvar k = 0; k < 3; k++) begin : g_out
        logic [QX-1:0] qx, qs;
        assign qx = QX'(quot[k]);
        assign qs = r_sd[SDK-1][k] ? QX'(-qx) : qx;
        always_ff @(posedge i_clk) begin
            if (en) r_dir[k] <= r_sd[SDK-1][3] ? '0 : qs[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_zero <= r_sd[SDK-1][3];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_dir[2], r_dir[1], r_dir[0]};
    assign m_axis_tuser  = r_zero;

    `CRD_ASSERT(a_zero_dir, i_clk, i_rst_n, !(r_out_valid && r_zero) || m_axis_tdata == '0)
    `CRD_ASSERT_NEXT(a_enter, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0])
    `CRD_ASSERT_NEXT(a_leave, i_clk, i_rst_n, r_vld[NST-1] && en, r_out_valid)
endmodule
